FILE: src/rld_pkg.sv
// rld_pkg: shared types, register indexes and saturation helpers for the
// radial lens distortion core
// no dependencies
`default_nettype none

package rld_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_K1_COEF   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_K2_COEF   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE = 3'd4;

  localparam logic [15:0] TOLERANCE_RESET = 16'd66;

  // -100000.0 pixels in Q48.16
  localparam logic signed [63:0] PREV_START = -64'sd6553600000;

  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};
  localparam logic signed [31:0] S32_MAX = {1'b0, {31{1'b1}}};
  localparam logic signed [31:0] S32_MIN = {1'b1, {31{1'b0}}};

  localparam int SHIFT_Q = 62;
  localparam int SHIFT_P = 60;
  localparam int SHIFT_T = 32;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQX,
    S_SQY,
    S_LOAD,
    S_MAC,
    S_NEG,
    S_SHF,
    S_KADD,
    S_CHECK
  } rld_state_t;

  typedef enum logic [1:0] {
    OP_Q,
    OP_P,
    OP_TX,
    OP_TY
  } rld_op_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v[65:31] == '0 || v[65:31] == '1) begin
      r = v[31:0];
    end else if (v[65]) begin
      r = S32_MIN;
    end else begin
      r = S32_MAX;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] sat64(input logic signed [64:0] v);
    logic signed [63:0] r;
    if (v[64] == v[63]) begin
      r = v[63:0];
    end else if (v[64]) begin
      r = S64_MIN;
    end else begin
      r = S64_MAX;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/radial_lens_distortion_core.sv
// radial_lens_distortion_core: radial lens distortion (k1, k2) and its
// iterative inverse, on one shared 32x32 multiplier under a small sequencer
// depends on rld_pkg
//
// channel  direction  handshake             word
// config   in         cfg_write             cfg_index, cfg_data
// input    in         in_valid / in_stall   mode, x_in, y_in
// output   out        out_valid / out_stall x_out, y_out, not_converged
//
// each pass is two squares, then four
// 64x64 products of four partial products each, all through the one 32x32 multiplier
// distort is one pass; undistort is 1 to MAX_ITERATIONS passes
// in_stall is high from accept until the result is loaded into the output register
// a result held by out_stall delays only the load of the next result
// rst is synchronous and restores the register reset values
`default_nettype none

module radial_lens_distortion_core #(
  parameter int MAX_ITERATIONS = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [rld_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [rld_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           mode,
  input  wire logic signed [31:0]             x_in,
  input  wire logic signed [31:0]             y_in,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [31:0]                  x_out,
  output logic signed [31:0]                  y_out,
  output logic                                not_converged
);
  import rld_pkg::*;

  localparam int PASS_W = $clog2(MAX_ITERATIONS + 1);

  rld_state_t state, state_next;
  rld_op_t    op;

  logic signed [31:0] center_x, center_y;
  logic signed [63:0] k1_coef, k2_coef;
  logic [15:0]        tolerance;

  logic               mode_r;
  logic signed [31:0] dx, dy, ux, uy;
  logic signed [63:0] px, py, r2, q, t, poly, tx, ty;
  logic [PASS_W-1:0]  pass;

  logic [63:0]  ma, mb;
  logic         mneg;
  logic [1:0]   pp;
  logic [127:0] acc;

  logic [31:0]  mul_a, mul_b;
  logic [63:0]  mul_p;
  logic [127:0] addend;
  logic [64:0]  sq_sum;

  logic signed [63:0]  op_a, op_b;
  logic signed [127:0] shifted;
  logic signed [63:0]  mres;

  logic signed [64:0] diff_x, diff_y;
  logic [64:0]        adiff_x, adiff_y;
  logic               conv;
  logic               last_pass;
  logic               out_free;
  logic               finish;
  logic signed [31:0] res_x, res_y;
  logic signed [31:0] abs_ux, abs_uy;

  always_comb begin
    abs_ux = ux[31] ? -ux : ux;
    abs_uy = uy[31] ? -uy : uy;
  end

  // shared multiplier
  always_comb begin
    case (state)
      S_SQX: begin
        mul_a = abs_ux;
        mul_b = abs_ux;
      end
      S_SQY: begin
        mul_a = abs_uy;
        mul_b = abs_uy;
      end
      default: begin
        mul_a = pp[1] ? ma[63:32] : ma[31:0];
        mul_b = pp[0] ? mb[63:32] : mb[31:0];
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    case (pp)
      2'd0:    addend = {64'd0, mul_p};
      2'd3:    addend = {mul_p, 64'd0};
      default: addend = {32'd0, mul_p, 32'd0};
    endcase
    sq_sum = {1'b0, r2} + {1'b0, mul_p};
  end

  always_comb begin
    case (op)
      OP_Q: begin
        op_a = k2_coef;
        op_b = r2;
      end
      OP_P: begin
        op_a = t;
        op_b = r2;
      end
      OP_TX: begin
        op_a = 64'(ux);
        op_b = poly;
      end
      default: begin
        op_a = 64'(uy);
        op_b = poly;
      end
    endcase
  end

  always_comb begin
    case (op)
      OP_Q:    shifted = $signed(acc) >>> SHIFT_Q;
      OP_P:    shifted = $signed(acc) >>> SHIFT_P;
      default: shifted = $signed(acc) >>> SHIFT_T;
    endcase
    if (shifted[127:63] == '0 || shifted[127:63] == '1) begin
      mres = shifted[63:0];
    end else if (shifted[127]) begin
      mres = S64_MIN;
    end else begin
      mres = S64_MAX;
    end
  end

  // convergence test and results
  always_comb begin
    diff_x    = {tx[63], tx} - {px[63], px};
    diff_y    = {ty[63], ty} - {py[63], py};
    adiff_x   = diff_x[64] ? 65'(-diff_x) : 65'(diff_x);
    adiff_y   = diff_y[64] ? 65'(-diff_y) : 65'(diff_y);
    conv      = (adiff_x < {49'd0, tolerance}) && (adiff_y < {49'd0, tolerance});
    last_pass = pass >= PASS_W'(MAX_ITERATIONS);
    if (mode_r) begin
      res_x = sat32(66'(dx) - 66'(tx));
      res_y = sat32(66'(dy) - 66'(ty));
    end else begin
      res_x = sat32(66'(dx) + 66'(tx));
      res_y = sat32(66'(dy) + 66'(ty));
    end
    out_free = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    finish     = 1'b0;
    in_stall   = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_SQX;
        end
      end
      S_SQX:  state_next = S_SQY;
      S_SQY:  state_next = S_LOAD;
      S_LOAD: state_next = S_MAC;
      S_MAC: begin
        if (pp == 2'd3) begin
          state_next = S_NEG;
        end
      end
      S_NEG: state_next = S_SHF;
      S_SHF: begin
        case (op)
          OP_Q:    state_next = S_KADD;
          OP_TY:   state_next = S_CHECK;
          default: state_next = S_LOAD;
        endcase
      end
      S_KADD: state_next = S_LOAD;
      S_CHECK: begin
        if (!mode_r || conv || last_pass) begin
          if (out_free) begin
            finish     = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_SQX;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x  <= '0;
      center_y  <= '0;
      k1_coef   <= '0;
      k2_coef   <= '0;
      tolerance <= TOLERANCE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CENTER_X:  center_x  <= cfg_data[31:0];
        REG_CENTER_Y:  center_y  <= cfg_data[31:0];
        REG_K1_COEF:   k1_coef   <= cfg_data;
        REG_K2_COEF:   k2_coef   <= cfg_data;
        REG_TOLERANCE: tolerance <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      x_out         <= res_x;
      y_out         <= res_y;
      not_converged <= mode_r && !conv;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          mode_r <= mode;
          dx     <= sat32(66'(x_in) - 66'(center_x));
          dy     <= sat32(66'(y_in) - 66'(center_y));
          ux     <= sat32(66'(x_in) - 66'(center_x));
          uy     <= sat32(66'(y_in) - 66'(center_y));
          px     <= PREV_START;
          py     <= PREV_START;
          pass   <= PASS_W'(1);
        end
      end
      S_SQX: begin
        r2 <= mul_p;
        op <= OP_Q;
      end
      S_SQY: begin
        r2 <= sq_sum[63] ? S64_MAX : sq_sum[63:0];
      end
      S_LOAD: begin
        ma   <= op_a[63] ? 64'(-op_a) : 64'(op_a);
        mb   <= op_b[63] ? 64'(-op_b) : 64'(op_b);
        mneg <= op_a[63] ^ op_b[63];
        acc  <= '0;
        pp   <= '0;
      end
      S_MAC: begin
        acc <= acc + addend;
        pp  <= pp + 2'd1;
      end
      S_NEG: begin
        if (mneg) begin
          acc <= -acc;
        end
      end
      S_SHF: begin
        case (op)
          OP_Q: q <= mres;
          OP_P: begin
            poly <= mres;
            op   <= OP_TX;
          end
          OP_TX: begin
            tx <= mres;
            op <= OP_TY;
          end
          default: ty <= mres;
        endcase
      end
      S_KADD: begin
        t  <= sat64(65'(k1_coef) + 65'(q));
        op <= OP_P;
      end
      S_CHECK: begin
        if (mode_r && !conv && !last_pass) begin
          px   <= tx;
          py   <= ty;
          ux   <= res_x;
          uy   <= res_y;
          pass <= pass + PASS_W'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
